// ===== design/tli_pkg.sv =====
`default_nettype none

package tli_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned EntryW  = 8;
  localparam int unsigned PointsW = 9;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = 5;

  localparam logic [PointsW-1:0] PointsReset = 9'd2;

  // req_type codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CAP_A,
    ST_CAP_B,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_WRITE,
    DP_LOAD,
    DP_OOR,
    DP_STEP,
    DP_CAP_A,
    DP_CAP_B,
    DP_MUL,
    DP_DIV
  } dp_op_e;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_MID,
    ADDR_LO,
    ADDR_LO1
  } addr_sel_e;

  typedef struct packed {
    dp_op_e    op;
    addr_sel_e addr;
    logic      rd_en;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic below_first;
    logic above_last;
    logic search_done;
    logic lo_is_last;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/tli_req_if.sv =====
`default_nettype none

interface tli_req_if import tli_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [EntryW-1:0] entry_index;
  logic [DataW-1:0]  abscissa;
  logic [DataW-1:0]  ordinate;

  modport source (output valid, req_type, entry_index, abscissa, ordinate, input ready);
  modport sink   (input valid, req_type, entry_index, abscissa, ordinate, output ready);
endinterface

`default_nettype wire

// ===== design/tli_res_if.sv =====
`default_nettype none

interface tli_res_if import tli_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] interpolated;
  logic             in_range;

  modport source (output valid, interpolated, in_range, input ready);
  modport sink   (input valid, interpolated, in_range, output ready);
endinterface

`default_nettype wire

// ===== design/tli_cfg_if.sv =====
`default_nettype none

interface tli_cfg_if import tli_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PointsW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/tli_ctrl.sv =====
`default_nettype none

module tli_ctrl import tli_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  input  wire logic    req_type_i,
  output logic         req_ready_o,
  input  wire logic    res_ready_i,
  output logic         res_valid_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        res_valid_q, res_valid_d;
  logic        out_free;

  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && req_type_i == REQ_QUERY) state_d = ST_RD_FIRST;
      end
      ST_RD_FIRST:  state_d = ST_CHK_FIRST;
      ST_CHK_FIRST: state_d = sts_i.below_first ? ST_FIN : ST_CHK_LAST;
      ST_CHK_LAST:  state_d = sts_i.above_last ? ST_FIN : ST_SRCH_RD;
      ST_SRCH_RD:   state_d = sts_i.search_done ? ST_CAP_A : ST_SRCH_CMP;
      ST_SRCH_CMP:  state_d = ST_SRCH_RD;
      ST_CAP_A:     state_d = sts_i.lo_is_last ? ST_FIN : ST_CAP_B;
      ST_CAP_B:     state_d = ST_MUL;
      ST_MUL:       state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '{op: DP_NOP, addr: ADDR_ZERO, rd_en: 1'b0, out_load: 1'b0};
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) cmd_o.op = (req_type_i == REQ_QUERY) ? DP_LOAD : DP_WRITE;
      end
      ST_RD_FIRST: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr  = ADDR_ZERO;
      end
      ST_CHK_FIRST: begin
        if (sts_i.below_first) begin
          cmd_o.op = DP_OOR;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.addr  = ADDR_LAST;
        end
      end
      ST_CHK_LAST: begin
        if (sts_i.above_last) cmd_o.op = DP_OOR;
      end
      ST_SRCH_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr  = sts_i.search_done ? ADDR_LO : ADDR_MID;
      end
      ST_SRCH_CMP: cmd_o.op = DP_STEP;
      ST_CAP_A: begin
        cmd_o.op = DP_CAP_A;
        if (!sts_i.lo_is_last) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.addr  = ADDR_LO1;
        end
      end
      ST_CAP_B: cmd_o.op = DP_CAP_B;
      ST_MUL:   cmd_o.op = DP_MUL;
      ST_DIV:   cmd_o.op = DP_DIV;
      ST_FIN:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_o.out_load) res_valid_d = 1'b1;
    else if (res_ready_i) res_valid_d = 1'b0;
  end

  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/tli_datapath.sv =====
`default_nettype none

module tli_datapath import tli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [EntryW-1:0]  entry_index_i,
  input  wire logic [DataW-1:0]   abscissa_i,
  input  wire logic [DataW-1:0]   ordinate_i,
  input  wire logic               cfg_we_i,
  input  wire logic [PointsW-1:0] cfg_data_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  output logic [DataW-1:0]        interpolated_o,
  output logic                    in_range_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  logic [DataW-1:0] abs_mem [TABLE_DEPTH];
  logic [DataW-1:0] ord_mem [TABLE_DEPTH];
  logic [DataW-1:0] rd_abs_q, rd_ord_q;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_en;

  logic [PointsW-1:0] points_q;
  logic [CntW-1:0]    n_clamped;
  logic [CntW-1:0]    n_q, lo_q, hi_q;
  logic [CntW:0]      lo_plus1, mid_sum;
  logic [AddrW-1:0]   mid;

  logic [DataW-1:0]   x_q, ea_q, ca_q, t_q, dx_q, diff_q, quot_q;
  logic               neg_q, inr_q;
  logic [2*DataW-1:0] prod_q;
  logic [DataW:0]     div_trial;
  logic [DataW:0]     div_sub;
  logic [DivCntW-1:0] cnt_q;
  logic [DataW-1:0]   res_val;
  logic [DataW-1:0]   interp_q;
  logic               in_range_q;

  // table writes beyond the depth are dropped
  assign wr_en   = (cmd_i.op == DP_WRITE) && (32'(entry_index_i) < TABLE_DEPTH);
  assign wr_addr = AddrW'(entry_index_i);

  assign lo_plus1 = {1'b0, lo_q} + 1'b1;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = AddrW'(mid_sum >> 1);

  always_comb begin
    case (cmd_i.addr)
      ADDR_ZERO: rd_addr = '0;
      ADDR_LAST: rd_addr = AddrW'(n_q - 1'b1);
      ADDR_MID:  rd_addr = mid;
      ADDR_LO:   rd_addr = AddrW'(lo_q);
      ADDR_LO1:  rd_addr = AddrW'(lo_plus1);
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      abs_mem[wr_addr] <= abscissa_i;
      ord_mem[wr_addr] <= ordinate_i;
    end
    if (cmd_i.rd_en) begin
      rd_abs_q <= abs_mem[rd_addr];
      rd_ord_q <= ord_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= PointsReset;
    end else if (cfg_we_i) begin
      points_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (points_q < PointsW'(2)) n_clamped = CntW'(2);
    else if (32'(points_q) > TABLE_DEPTH) n_clamped = CntW'(TABLE_DEPTH);
    else n_clamped = CntW'(points_q);
  end

  assign sts_o.below_first = x_q < rd_abs_q;
  assign sts_o.above_last  = x_q > rd_abs_q;
  assign sts_o.search_done = {1'b0, hi_q} <= lo_plus1;
  assign sts_o.lo_is_last  = lo_q == (n_q - 1'b1);
  assign sts_o.div_done    = cnt_q == DivCntW'(DivSteps - 1);

  // one restoring division step: remainder in the upper half of prod_q
  assign div_trial = {prod_q[2*DataW-1:DataW], prod_q[DataW-1]};
  assign div_sub   = div_trial - {1'b0, dx_q};

  assign res_val = neg_q ? (ca_q - quot_q) : (ca_q + quot_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        x_q  <= abscissa_i;
        n_q  <= n_clamped;
        lo_q <= '0;
        hi_q <= n_clamped;
      end
      DP_OOR: begin
        ca_q   <= '0;
        quot_q <= '0;
        neg_q  <= 1'b0;
        inr_q  <= 1'b0;
      end
      DP_STEP: begin
        if (rd_abs_q > x_q) hi_q <= CntW'(mid);
        else lo_q <= CntW'(mid);
      end
      DP_CAP_A: begin
        ea_q   <= rd_abs_q;
        ca_q   <= rd_ord_q;
        t_q    <= x_q - rd_abs_q;
        quot_q <= '0;
        neg_q  <= 1'b0;
        inr_q  <= 1'b1;
      end
      DP_CAP_B: begin
        dx_q   <= rd_abs_q - ea_q;
        neg_q  <= rd_ord_q < ca_q;
        diff_q <= (rd_ord_q < ca_q) ? (ca_q - rd_ord_q) : (rd_ord_q - ca_q);
      end
      DP_MUL: begin
        prod_q <= (2*DataW)'(diff_q) * (2*DataW)'(t_q);
        cnt_q  <= '0;
      end
      DP_DIV: begin
        if (!div_sub[DataW]) begin
          prod_q <= {div_sub[DataW-1:0], prod_q[DataW-2:0], 1'b0};
          quot_q <= {quot_q[DataW-2:0], 1'b1};
        end else begin
          prod_q <= {div_trial[DataW-1:0], prod_q[DataW-2:0], 1'b0};
          quot_q <= {quot_q[DataW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      interp_q   <= res_val;
      in_range_q <= inr_q;
    end
  end

  assign interpolated_o = interp_q;
  assign in_range_o     = in_range_q;

endmodule

`default_nettype wire

// ===== design/table_linear_interpolator.sv =====
// Piecewise-linear table interpolator, unsigned Q16.16.
// req_i carries transactions of two kinds: req_type REQ_WRITE stores one
// point (abscissa, ordinate) at entry_index and gives no result; REQ_QUERY
// returns one transaction on res_o with the interpolated value and in_range.
// cfg_i sets points_in_use (clamped to 2..TABLE_DEPTH); write it while idle.
// A query runs a binary search over the n points in use, which needs a
// compare step after each table read on the single read port, and the
// quotient comes from a restoring divider at one bit per cycle.
// A query that lands on the last point skips the divider.
// Out-of-range queries skip the search and finish with zero and in_range low.
// The result sits in an output register; a new transaction is taken while
// it waits, and a query holds its result internally until res_o is free.
// Reset clears control state and sets points_in_use to 2; table contents
// are undefined until written, and queries must only reach written entries.
`default_nettype none

module table_linear_interpolator import tli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tli_req_if.sink   req_i,
  tli_res_if.source res_o,
  tli_cfg_if.sink   cfg_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  tli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_index_i  (req_i.entry_index),
    .abscissa_i     (req_i.abscissa),
    .ordinate_i     (req_i.ordinate),
    .cfg_we_i       (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .interpolated_o (res_o.interpolated),
    .in_range_o     (res_o.in_range)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench import tli_pkg::*; ();

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned ITEM_TARGET  = 800;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES   = 80;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned GAP_PCT      = 86;
  localparam int unsigned LIGHT_PCT    = 7;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic              req_type;
    logic [EntryW-1:0] entry_index;
    logic [DataW-1:0]  abscissa;
    logic [DataW-1:0]  ordinate;
  } request_t;

  typedef struct packed {
    logic [DataW-1:0] interpolated;
    logic             in_range;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tli_req_if req_bus ();
  tli_res_if res_bus ();
  tli_cfg_if cfg_bus ();

  table_linear_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor state, updated on accepted transactions
  logic [DataW-1:0]   absc_tbl [TABLE_DEPTH];
  logic [DataW-1:0]   ord_tbl  [TABLE_DEPTH];
  logic [PointsW-1:0] points_cfg = PointsReset;

  // Stimulus-side mirror of the table, updated as items are queued
  logic [DataW-1:0]   plan_absc [TABLE_DEPTH];
  logic [DataW-1:0]   plan_ord  [TABLE_DEPTH];

  request_t    request_q[$];
  result_t     expected_q[$];
  request_t    bus_item;
  result_t     expected_res;
  idle_mode_e  idle_mode = IDLE_NONE;
  logic        res_hold = 1'b0;
  logic        hold_armed = 1'b0;
  int unsigned error_count = 0;
  int unsigned planned_items = 0;

  function automatic int unsigned used_points(input logic [PointsW-1:0] v);
    if (v < 2) return 2;
    if (v > TABLE_DEPTH) return TABLE_DEPTH;
    return 32'(v);
  endfunction

  function automatic result_t interpolate_point(input logic [DataW-1:0] x);
    result_t            r;
    int unsigned        n, lo, hi, mid;
    logic [DataW-1:0]   ea, eb, ca, cb, dc, dt, dw;
    logic [2*DataW-1:0] prod, quot;
    n = used_points(points_cfg);
    r.interpolated = '0;
    r.in_range     = 1'b0;
    if (x < absc_tbl[0] || x > absc_tbl[n-1]) return r;
    lo = 0;
    hi = n;
    while (hi > lo + 1) begin
      mid = (lo + hi) >> 1;
      if (absc_tbl[mid] > x) hi = mid;
      else lo = mid;
    end
    r.in_range = 1'b1;
    if (lo >= n - 1) begin
      r.interpolated = ord_tbl[n-1];
      return r;
    end
    ea = absc_tbl[lo];
    eb = absc_tbl[lo+1];
    ca = ord_tbl[lo];
    cb = ord_tbl[lo+1];
    if (eb <= ea) begin
      r.interpolated = ca;
      return r;
    end
    dt = x - ea;
    dw = eb - ea;
    dc = (cb >= ca) ? cb - ca : ca - cb;
    // full 64-bit product before the truncating division
    prod = {{DataW{1'b0}}, dc} * {{DataW{1'b0}}, dt};
    quot = prod / {{DataW{1'b0}}, dw};
    r.interpolated = (cb >= ca) ? ca + quot[DataW-1:0] : ca - quot[DataW-1:0];
    return r;
  endfunction

  function automatic void apply_request(input request_t it);
    if (it.req_type == REQ_WRITE) begin
      absc_tbl[it.entry_index] = it.abscissa;
      ord_tbl[it.entry_index]  = it.ordinate;
    end else begin
      expected_q.insert(expected_q.size(), interpolate_point(it.abscissa));
    end
  endfunction

  function automatic logic sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < GAP_PCT;
      IDLE_BOTH:   return $urandom_range(99) < LIGHT_PCT;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < GAP_PCT;
      IDLE_BOTH:     return $urandom_range(99) < LIGHT_PCT;
      default:       return 1'b0;
    endcase
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) apply_request(bus_item);
      if (!req_bus.valid || req_bus.ready) begin
        if (request_q.size() != 0 && !sender_gap()) begin
          bus_item = request_q.pop_front();
          req_bus.valid       <= 1'b1;
          req_bus.req_type    <= bus_item.req_type;
          req_bus.entry_index <= bus_item.entry_index;
          req_bus.abscissa    <= bus_item.abscissa;
          req_bus.ordinate    <= bus_item.ordinate;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, actual interpolated %h in_range %b",
                   $time, res_bus.interpolated, res_bus.in_range);
        end else begin
          expected_res = expected_q.pop_front();
          if (res_bus.interpolated !== expected_res.interpolated) begin
            error_count++;
            $display("%0t: interpolated mismatch: expected %h, actual %h",
                     $time, expected_res.interpolated, res_bus.interpolated);
          end
          if (res_bus.in_range !== expected_res.in_range) begin
            error_count++;
            $display("%0t: in_range mismatch: expected %b, actual %b",
                     $time, expected_res.in_range, res_bus.in_range);
          end
        end
      end
      res_bus.ready <= !res_hold && !receiver_stall();
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    res_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    res_hold <= 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

  task automatic push_request(input logic req_type, input logic [EntryW-1:0] idx,
                              input logic [DataW-1:0] x, input logic [DataW-1:0] y);
    request_t it;
    it.req_type    = req_type;
    it.entry_index = idx;
    it.abscissa    = x;
    it.ordinate    = y;
    request_q.insert(request_q.size(), it);
    planned_items++;
    if (req_type == REQ_WRITE) begin
      plan_absc[idx] = x;
      plan_ord[idx]  = y;
    end
  endtask

  // Narrow tables allow repeated abscissae, which gives non-increasing segments
  task automatic load_table(input int unsigned n, input logic narrow);
    logic [DataW-1:0] max_step, e;
    int unsigned      i;
    max_step = narrow ? 32'h0004_0000 : 32'hFFFF_FFFF / n;
    e = $urandom_range(max_step);
    for (i = 0; i < n; i++) begin
      push_request(REQ_WRITE, EntryW'(i), e, $urandom);
      if (i < n - 1) e = e + $urandom_range(max_step, narrow ? 0 : 1);
    end
  endtask

  function automatic logic [DataW-1:0] pick_query(input int unsigned n);
    int unsigned      sel, i;
    logic [DataW-1:0] lo_e, hi_e;
    sel = $urandom_range(99);
    if (sel < 65) begin
      i = $urandom_range(n - 2);
      lo_e = plan_absc[i];
      hi_e = plan_absc[i+1];
      if (hi_e > lo_e) return lo_e + ($urandom % (hi_e - lo_e));
      return lo_e;
    end
    if (sel < 80) return plan_absc[$urandom_range(n - 1)];
    if (sel < 88) begin
      if ($urandom_range(1) == 0 && plan_absc[0] != '0) return plan_absc[0] - 1;
      return plan_absc[n-1] + 1;
    end
    return $urandom;
  endfunction

  task automatic run_traffic(input int unsigned n, input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 15) begin
        push_request(REQ_WRITE, EntryW'($urandom), $urandom, $urandom);
      end else begin
        push_request(REQ_QUERY, EntryW'($urandom), pick_query(n), $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || req_bus.valid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_points(input logic [PointsW-1:0] v);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    points_cfg = v;
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    logic [PointsW-1:0] cfg_plan [6];
    logic [PointsW-1:0] cfg_val;
    int unsigned        phase, n;
    cfg_plan = '{9'd0, 9'd511, 9'd256, 9'd1, 9'd3, 9'd2};
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_WRITE;
    req_bus.entry_index = '0;
    req_bus.abscissa    = '0;
    req_bus.ordinate    = '0;
    res_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.data        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two points in use after reset
    push_request(REQ_WRITE, 8'd0, 32'h0001_0000, 32'h0000_1000);
    push_request(REQ_WRITE, 8'd1, 32'h0003_0000, 32'h0009_0000);
    push_request(REQ_QUERY, 8'd0, 32'h0000_FFFF, 32'h0);          // below first
    push_request(REQ_QUERY, 8'd0, 32'h0001_0000, 32'h0);          // on first point
    push_request(REQ_QUERY, 8'd0, 32'h0002_0000, 32'h0);
    push_request(REQ_QUERY, 8'd0, 32'h0003_0000, 32'h0);          // top endpoint
    push_request(REQ_QUERY, 8'd0, 32'h0003_0001, 32'h0);          // above last
    push_request(REQ_WRITE, 8'd1, 32'h0003_0000, 32'h0000_0000);  // falling ordinate
    push_request(REQ_QUERY, 8'd0, 32'h0002_8000, 32'h0);
    push_request(REQ_WRITE, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(REQ_WRITE, 8'd1, 32'hFFFF_FFFF, 32'h0000_0000);
    push_request(REQ_QUERY, 8'd0, 32'h0000_0000, 32'h0);
    push_request(REQ_QUERY, 8'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push_request(REQ_QUERY, 8'd0, 32'hFFFF_FFFF, 32'h0);
    push_request(REQ_WRITE, 8'd0, 32'h0000_0000, 32'h0000_0000);
    push_request(REQ_WRITE, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(REQ_QUERY, 8'd0, 32'h8000_0000, 32'h0);
    push_request(REQ_WRITE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(REQ_WRITE, 8'd1, 32'h0000_0000, 32'h0000_0005);  // repeated abscissa
    push_request(REQ_QUERY, 8'd0, 32'h0000_0000, 32'h0);
    push_request(REQ_QUERY, 8'd0, 32'h0000_0001, 32'h0);
    wait_drained();
    planned_items = 0;

    phase = 0;
    while (planned_items < ITEM_TARGET) begin
      cfg_val   = (phase < 6) ? cfg_plan[phase] : PointsW'($urandom_range(40, 4));
      idle_mode = idle_mode_e'(phase % 4);
      write_points(cfg_val);
      n = used_points(cfg_val);
      // the third phase keeps the full table loaded by the second
      if (phase != 2) load_table(n, $urandom_range(1));
      if (cfg_val == 9'd3) begin
        hold_armed = 1'b1;
        run_traffic(n, 90);
      end else begin
        run_traffic(n, 50);
      end
      wait_drained();
      phase++;
    end

    repeat (END_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
